FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion check failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion never failed");

`else

`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

    // word width of stored and returned items
    localparam int DATA_W = 32;

    // width of the capacity register
    localparam int CAP_W = 5;

    // capacity after reset
    localparam int RESET_CAP = 16;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_POP_REAR   = 2'd1,
        OP_PUSH_FRONT = 2'd2,
        OP_POP_FRONT  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

endpackage

FILE: rtl/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// double-ended queue of 32-bit words kept in a circular memory
// ----------------------------------------------------------------------------
//
// channel   | dir | tdata                  | tuser
// ----------+-----+------------------------+----------------------
// s_*       | in  | [31:0] push_value      | [1:0] op
// m_*       | out | [31:0] pop_value       | [1:0] status
// cfg_*     | in  | cfg_wr_data [4:0] capacity, written when cfg_wr_en is high
//
// one item is accepted per cycle while s_tready is high; its result sits in
// the output register in the next cycle. the front/rear index update, done in
// the accepting cycle, is the loop that sets this rate; the memory read lands
// in the output register. s_tready is high while the output register is free
// or being taken. reset (async) empties the deque and sets capacity to 16;
// stored words stay undefined until pushed, so there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque_core #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items: tdata = push_value, tuser = op
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdq_pkg::DATA_W-1:0]    s_tdata,     // [31:0] push_value
    input  logic [1:0]                    s_tuser,     // [1:0] op
    // result items: tdata = pop_value, tuser = status
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::DATA_W-1:0]    m_tdata,     // [31:0] pop_value
    output logic [1:0]                    m_tuser,     // [1:0] status
    // capacity register
    input  logic                          cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]     cfg_wr_data
);

    import cdq_pkg::*;

    localparam int IW  = $clog2(DEPTH);
    localparam int CPW = IW + 1;
    localparam int RST_CAP = (DEPTH < RESET_CAP) ? DEPTH : RESET_CAP;

    logic [IW-1:0]     front_reg, front_next;
    logic [IW-1:0]     rear_reg, rear_next;
    logic              empty_reg, empty_next;
    logic [CPW-1:0]    cap_reg;
    logic [CPW-1:0]    cap_eff;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;

    logic              in_acc;
    op_t               op;
    logic [IW-1:0]     cap_m1;
    logic [IW-1:0]     next_rear;
    logic [IW-1:0]     next_front;
    logic [IW-1:0]     prev_rear;
    logic [IW-1:0]     prev_front;
    logic              full;
    logic              is_push;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    // handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign is_push  = (op == OP_PUSH_REAR) || (op == OP_PUSH_FRONT);

    // wrapped neighbor indices
    assign cap_m1     = IW'(cap_reg - CPW'(1));
    assign next_rear  = (rear_reg == cap_m1) ? '0 : IW'(rear_reg + IW'(1));
    assign next_front = (front_reg == cap_m1) ? '0 : IW'(front_reg + IW'(1));
    assign prev_rear  = (rear_reg == '0) ? cap_m1 : IW'(rear_reg - IW'(1));
    assign prev_front = (front_reg == '0) ? cap_m1 : IW'(front_reg - IW'(1));
    assign full       = !empty_reg && (next_rear == front_reg);

    // capacity clamp to 1..DEPTH
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_eff = CPW'(1);
        end
        else if (32'(cfg_wr_data) > 32'(DEPTH))
        begin
            cap_eff = CPW'(DEPTH);
        end
        else
        begin
            cap_eff = CPW'(cfg_wr_data);
        end
    end

    // operation decode, index update and memory access
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = rear_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        if (in_acc)
        begin
            unique case (op) inside
                OP_PUSH_REAR, OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else if (empty_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                    end
                    else if (op == OP_PUSH_REAR)
                    begin
                        rear_next = next_rear;
                        wr_en     = 1'b1;
                        wr_addr   = next_rear;
                    end
                    else
                    begin
                        front_next = prev_front;
                        wr_en      = 1'b1;
                        wr_addr    = prev_front;
                    end
                end
                OP_POP_REAR, OP_POP_FRONT:
                begin
                    if (empty_reg)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else if (front_reg == rear_reg)
                    begin
                        pop_ok_next = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = front_reg;
                        front_next  = '0;
                        rear_next   = '0;
                        empty_next  = 1'b1;
                    end
                    else if (op == OP_POP_REAR)
                    begin
                        pop_ok_next = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = rear_reg;
                        rear_next   = prev_rear;
                    end
                    else
                    begin
                        pop_ok_next = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = front_reg;
                        front_next  = next_front;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // output register occupancy
    always_comb
    begin
        if (in_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state, a capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            empty_reg     <= 1'b1;
            cap_reg       <= CPW'(RST_CAP);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg   <= cap_eff;
                front_reg <= '0;
                rear_reg  <= '0;
                empty_reg <= 1'b1;
            end
            else
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                empty_reg <= empty_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // word store
    cdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result drive
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pop_ok_reg ? rd_data : '0;
    assign m_tuser  = status_reg;

    // empty deque keeps both indices at zero
    `ASSERT_CHK(a_empty_idx, clk, rst_n, empty_reg |-> (front_reg == '0 && rear_reg == '0))

    // indices stay below the capacity
    `ASSERT_CHK(a_idx_range, clk, rst_n, ({1'b0, front_reg} < cap_reg) && ({1'b0, rear_reg} < cap_reg))

    // an overflowing push leaves the indices alone
    `ASSERT_CHK(a_ovf_hold, clk, rst_n, (in_acc && is_push && full && !cfg_wr_en) |=> ($stable(front_reg) && $stable(rear_reg) && !empty_reg))

    // one item never both writes and reads the store
    `ASSERT_NEVER(a_rw_excl, clk, rst_n, wr_en && rd_en)

endmodule

FILE: rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// simple dual-port word store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [cdq_pkg::DATA_W-1:0]          wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [cdq_pkg::DATA_W-1:0]          rd_data
);

    import cdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sim/tb_circular_deque_core.sv
// ----------------------------------------------------------------------------
// tb_circular_deque_core
// self-checking testbench of the circular deque core
// ----------------------------------------------------------------------------
// A short table of directed items covers underflow after reset, the extreme
// words, overflow, the zero and oversized capacities, and a capacity write
// over a non-empty deque. It is followed by random bursts of pushes and pops
// that fill and drain the deque. The phases use several capacities and
// several idle and stall patterns. A behavioral deque in the testbench
// predicts the results not typed in the table; a scoreboard checks all in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_deque_core;

    import cdq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CLK_HALF   = 5;
    localparam int PHASE_LEN  = 119;
    localparam int NUM_PHASES = 8;

    // idle and stall patterns of the two stream sides
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // one result item as the deque should produce it
    typedef struct {
        logic [DATA_W-1:0] pop_value;
        status_t           status;
    } outcome_t;

    // one row of the directed table
    typedef struct {
        int                cfg_value;   // capacity written first, -1 for none
        op_t               op;
        logic [DATA_W-1:0] value;
        bit                typed;       // use the typed-in result below
        logic [DATA_W-1:0] exp_value;
        status_t           exp_status;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;

    // behavioral deque
    logic [DATA_W-1:0] word_store [DEPTH];
    logic [3:0]        front_idx;
    logic [3:0]        rear_idx;
    logic              dq_empty;
    logic [CAP_W-1:0]  cap_reg;

    outcome_t   outcome_q [$];
    stim_row_t  stim_rows [$];
    outcome_t   seen;
    idle_mode_t idle_mode = IDLE_NONE;
    int         errors = 0;

    circular_deque_core #(
        .DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [31:0] push_value
        .s_tuser     (s_tuser),     // [1:0] op
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [31:0] pop_value
        .m_tuser     (m_tuser),     // [1:0] status
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // random pause decision at a given percentage
    function automatic bit stall_now(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // next state and result of the deque for one operation
    task automatic compute_deque_result(input op_t op, input logic [DATA_W-1:0] val,
                                        output outcome_t res);
        logic [CAP_W-1:0] cap;
        logic [CAP_W-1:0] wide_next;
        logic [3:0]       next_rear;
        logic             full;
        cap = cap_reg;
        if (cap == '0)
            cap = CAP_W'(1);
        if (cap > DEPTH)
            cap = CAP_W'(DEPTH);
        wide_next = ({1'b0, rear_idx} + 5'd1) % cap;
        next_rear = wide_next[3:0];
        full = !dq_empty && next_rear == front_idx;
        res.pop_value = '0;
        res.status = ST_OK;
        if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT)
        begin
            if (full)
                res.status = ST_OVERFLOW;
            else if (dq_empty)
            begin
                // first word always lands at position zero
                front_idx = '0;
                rear_idx = '0;
                dq_empty = 1'b0;
                word_store[0] = val;
            end
            else if (op == OP_PUSH_REAR)
            begin
                rear_idx = next_rear;
                word_store[rear_idx] = val;
            end
            else
            begin
                front_idx = (front_idx == '0) ? 4'(cap - 5'd1) : front_idx - 4'd1;
                word_store[front_idx] = val;
            end
        end
        else
        begin
            if (dq_empty)
                res.status = ST_UNDERFLOW;
            else if (front_idx == rear_idx)
            begin
                // last element leaves, deque goes back to empty
                res.pop_value = word_store[front_idx];
                front_idx = '0;
                rear_idx = '0;
                dq_empty = 1'b1;
            end
            else if (op == OP_POP_REAR)
            begin
                res.pop_value = word_store[rear_idx];
                rear_idx = (rear_idx == '0) ? 4'(cap - 5'd1) : rear_idx - 4'd1;
            end
            else
            begin
                res.pop_value = word_store[front_idx];
                wide_next = ({1'b0, front_idx} + 5'd1) % cap;
                front_idx = wide_next[3:0];
            end
        end
    endtask

    // present one item, wait for acceptance, record its result
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] val, input bit typed,
                             input logic [DATA_W-1:0] exp_value, input status_t exp_status);
        int       gap_pct;
        outcome_t res;
        gap_pct = (idle_mode == IDLE_SEND) ? 78 : (idle_mode == IDLE_BOTH) ? 35 : 0;
        while (stall_now(gap_pct))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= val;
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        compute_deque_result(op, val, res);
        if (typed)
        begin
            res.pop_value = exp_value;
            res.status = exp_status;
        end
        outcome_q.push_back(res);
        @(negedge clk);
    endtask

    // wait until every result is in, then write the capacity register
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cap_reg = cap;
        front_idx = '0;
        rear_idx = '0;
        dq_empty = 1'b1;
    endtask

    task automatic add_row(input int cfg_value, input op_t op, input logic [DATA_W-1:0] value,
                           input bit typed, input logic [DATA_W-1:0] exp_value,
                           input status_t exp_status);
        stim_row_t row;
        row.cfg_value = cfg_value;
        row.op = op;
        row.value = value;
        row.typed = typed;
        row.exp_value = exp_value;
        row.exp_status = exp_status;
        stim_rows.push_back(row);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (idle_mode == IDLE_RECV)
            m_tready <= !stall_now(78);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= !stall_now(35);
        else
            m_tready <= 1'b1;
    end

    // scoreboard: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result item pop_value=%h status=%0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                seen = outcome_q.pop_front();
                if (m_tdata !== seen.pop_value)
                begin
                    $display("%0t: pop_value mismatch, expected %h, actual %h",
                             $time, seen.pop_value, m_tdata);
                    errors++;
                end
                if (m_tuser !== seen.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, seen.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // hard limit on the run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // main stimulus
    initial
    begin
        int               phase;
        int               sent;
        int               burst_len;
        int               cap_eff;
        bit               push_heavy;
        bit               want_push;
        op_t              op;
        logic [DATA_W-1:0] val;
        int               phase_caps [NUM_PHASES];

        phase_caps = '{16, 1, 31, 3, 0, 8, 17, 5};
        cap_reg = CAP_W'(RESET_CAP);
        front_idx = '0;
        rear_idx = '0;
        dq_empty = 1'b1;

        // directed table
        add_row(-1, OP_POP_REAR,   32'h0000_0000, 1, 32'h0000_0000, ST_UNDERFLOW);
        add_row(-1, OP_POP_FRONT,  32'h1234_5678, 1, 32'h0000_0000, ST_UNDERFLOW);
        add_row(-1, OP_PUSH_REAR,  32'h7FFF_FFFF, 1, 32'h0000_0000, ST_OK);
        add_row(-1, OP_POP_REAR,   32'h0000_0000, 1, 32'h7FFF_FFFF, ST_OK);
        add_row(-1, OP_PUSH_FRONT, 32'h8000_0000, 1, 32'h0000_0000, ST_OK);
        add_row(-1, OP_PUSH_REAR,  32'hFFFF_FFFF, 0, '0, ST_OK);
        add_row(-1, OP_PUSH_FRONT, 32'h0000_0000, 0, '0, ST_OK);
        add_row(-1, OP_POP_FRONT,  32'hFFFF_FFFF, 0, '0, ST_OK);
        add_row(-1, OP_POP_REAR,   32'h0000_0000, 1, 32'hFFFF_FFFF, ST_OK);
        add_row(-1, OP_POP_FRONT,  32'h0000_0000, 1, 32'h8000_0000, ST_OK);
        // zero capacity acts as one entry
        add_row(0,  OP_PUSH_REAR,  32'hA5A5_A5A5, 1, 32'h0000_0000, ST_OK);
        add_row(-1, OP_PUSH_FRONT, 32'h5A5A_5A5A, 1, 32'h0000_0000, ST_OVERFLOW);
        add_row(-1, OP_POP_FRONT,  32'h0000_0000, 1, 32'hA5A5_A5A5, ST_OK);
        // two entries: fill, overflow, drain from the rear, then underflow
        add_row(2,  OP_PUSH_REAR,  32'h0000_0001, 0, '0, ST_OK);
        add_row(-1, OP_PUSH_FRONT, 32'h0000_0002, 0, '0, ST_OK);
        add_row(-1, OP_PUSH_REAR,  32'h0000_0003, 1, 32'h0000_0000, ST_OVERFLOW);
        add_row(-1, OP_POP_REAR,   32'h0000_0000, 0, '0, ST_OK);
        add_row(-1, OP_POP_REAR,   32'h0000_0000, 0, '0, ST_OK);
        add_row(-1, OP_POP_FRONT,  32'h0000_0000, 1, 32'h0000_0000, ST_UNDERFLOW);
        // oversized capacity saturates
        add_row(31, OP_PUSH_FRONT, 32'h1234_5678, 0, '0, ST_OK);
        add_row(-1, OP_PUSH_REAR,  32'hDEAD_BEEF, 0, '0, ST_OK);
        // capacity write over a non-empty deque empties it
        add_row(16, OP_POP_FRONT,  32'h0000_0000, 1, 32'h0000_0000, ST_UNDERFLOW);
        add_row(-1, OP_PUSH_REAR,  32'hCAFE_F00D, 0, '0, ST_OK);
        add_row(-1, OP_POP_FRONT,  32'h0000_0000, 0, '0, ST_OK);

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].cfg_value >= 0)
                write_capacity(stim_rows[i].cfg_value[CAP_W-1:0]);
            send_item(stim_rows[i].op, stim_rows[i].value, stim_rows[i].typed,
                      stim_rows[i].exp_value, stim_rows[i].exp_status);
        end

        // random bursts that fill and drain the deque
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_capacity(phase_caps[phase][CAP_W-1:0]);
            idle_mode = idle_mode_t'(phase % 4);
            cap_eff = (phase_caps[phase] == 0) ? 1 :
                      (phase_caps[phase] > DEPTH) ? DEPTH : phase_caps[phase];
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                burst_len = $urandom_range(1, 2 * cap_eff + 2);
                if (burst_len > PHASE_LEN - sent)
                    burst_len = PHASE_LEN - sent;
                push_heavy = $urandom_range(0, 1);
                repeat (burst_len)
                begin
                    want_push = ($urandom_range(0, 99) < 85) ? push_heavy : !push_heavy;
                    if (want_push)
                        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                    else
                        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
                    case ($urandom_range(0, 11))
                        0: val = 32'h0000_0000;
                        1: val = 32'hFFFF_FFFF;
                        2: val = 32'h8000_0000;
                        3: val = 32'h7FFF_FFFF;
                        default: val = $urandom;
                    endcase
                    send_item(op, val, 0, '0, ST_OK);
                    sent++;
                    // hold off once mid-phase until the pipeline drains
                    if (phase == 2 && sent == PHASE_LEN / 2)
                    begin
                        s_tvalid <= 1'b0;
                        while (outcome_q.size() != 0)
                            @(negedge clk);
                    end
                end
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
